// ===== sv/motor_valve_controller_macros.svh =====
// Assertion macros for the motor valve controller.
`ifndef MOTOR_VALVE_CONTROLLER_MACROS_SVH
`define MOTOR_VALVE_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define MVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MVC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVC_ASSERT(label, prop, msg)
`define MVC_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== sv/mvc_pkg.sv =====
// Types and constants shared by the motor valve controller modules.
package mvc_pkg;

  localparam int TRAVEL_W = 16;
  localparam int TPS_W    = 8;
  localparam int PULSE_W  = 8;
  localparam int STATUS_W = 9;
  localparam int DRIVE_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [TRAVEL_W-1:0] TRAVEL_TIME_RST      = 16'd60;
  localparam logic [TPS_W-1:0]    TICKS_PER_SECOND_RST = 8'd10;
  localparam logic [PULSE_W-1:0]  PULSE_SECONDS_RST    = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAVEL_TIME      = 2'd0,
    CFG_TICKS_PER_SECOND = 2'd1,
    CFG_PULSE_SECONDS    = 2'd2
  } cfg_idx_t;

  // Status word bit positions
  localparam int ST_REMOTE   = 0;
  localparam int ST_OPENING  = 1;
  localparam int ST_CLOSING  = 2;
  localparam int ST_CLUTCH   = 3;
  localparam int ST_TO_OPEN  = 4;
  localparam int ST_TO_CLOSE = 5;
  localparam int ST_OPENED   = 6;
  localparam int ST_CLOSED   = 7;
  localparam int ST_POWER    = 8;

  // Drive bit positions
  localparam int DRV_OPEN  = 0;
  localparam int DRV_CLOSE = 1;
  localparam int DRV_STOP  = 2;

  typedef struct packed {
    logic first_run;
    logic remote_mode;
    logic cmd_open;
    logic cmd_close;
    logic cmd_stop;
    logic clutch_alarm;
    logic limit_open;
    logic limit_closed;
    logic power_present;
  } item_t;

  typedef struct packed {
    logic                drive_open;
    logic                drive_close;
    logic                drive_stop;
    logic [TRAVEL_W-1:0] travel_left;
    logic [STATUS_W-1:0] status_word;
  } result_t;

  typedef struct packed {
    logic [TRAVEL_W-1:0] travel_time;
    logic [TPS_W-1:0]    ticks_per_second;
    logic [PULSE_W-1:0]  pulse_seconds;
  } cfg_t;

  typedef struct packed {
    logic [TPS_W-1:0]    second_divider;
    logic [PULSE_W-1:0]  pulse_hold;
    logic [TRAVEL_W-1:0] travel_counter;
    logic [STATUS_W-1:0] status_flags;
    logic [DRIVE_W-1:0]  drive_bits;
  } state_t;

endpackage

// ===== sv/motor_valve_controller.sv =====
// Top level of the motor valve controller: item pipeline, state and checks.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one control tick per item.
//   result channel (result_valid/result_ready/result) returns one result per item,
//   in order: drive pulses, remaining travel seconds and the status word.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes travel time,
//   ticks per second and pulse seconds; cfg_ready is always high. Write it
//   only while no item is in flight.
// Pipeline: an accepted item is registered in the input register, then the
//   tick logic feeds the result register, which raises result_valid.
// Throughput: one item per cycle while the result does not stall; the tick logic is
//   combinational and the controller state updates as the item enters the result register.
// Reset: rst clears both pipeline stages and the controller state and loads
//   the register defaults (60 s travel, 10 ticks per second, 2 s pulses).
// Stall: while result_ready is low the result holds; one more item is taken
//   into the input register, then item_ready drops until the result drains.
module motor_valve_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mvc_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mvc_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvc_pkg::TRAVEL_W-1:0]  cfg_data
);

  `include "motor_valve_controller_macros.svh"

  mvc_pkg::cfg_t    cfg;
  mvc_pkg::state_t  state;
  mvc_pkg::state_t  state_next;
  mvc_pkg::item_t   item_q;
  logic             item_q_valid;
  mvc_pkg::result_t result_next;
  logic             advance;
  logic             drive_local;
  logic             both_moving;

  assign cfg_ready  = 1'b1;
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  mvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mvc_step u_step (
    .cfg    (cfg),
    .cur    (state),
    .item   (item_q),
    .nxt    (state_next),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign drive_local = (result.drive_open || result.drive_close || result.drive_stop) &&
                       !result.status_word[mvc_pkg::ST_REMOTE];
  assign both_moving = state.status_flags[mvc_pkg::ST_OPENING] &&
                       state.status_flags[mvc_pkg::ST_CLOSING];

  `MVC_ASSERT_RST(a_reset_empty, rst |=> !result_valid && !item_q_valid, "pipeline not empty")
  `MVC_ASSERT(a_drive_remote, !(result_valid && drive_local), "drive pulse outside remote mode")
  `MVC_ASSERT(a_one_motion, !both_moving, "opening and closing both set")
  `MVC_ASSERT(a_state_hold, !advance |=> $stable(state), "state changed without an item")

endmodule

// ===== sv/mvc_cfg_regs.sv =====
// Configuration register file of the motor valve controller.
module mvc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [mvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvc_pkg::TRAVEL_W-1:0] cfg_data,
  output mvc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_time      <= mvc_pkg::TRAVEL_TIME_RST;
      cfg.ticks_per_second <= mvc_pkg::TICKS_PER_SECOND_RST;
      cfg.pulse_seconds    <= mvc_pkg::PULSE_SECONDS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mvc_pkg::CFG_TRAVEL_TIME: begin
          cfg.travel_time <= cfg_data;
        end
        mvc_pkg::CFG_TICKS_PER_SECOND: begin
          cfg.ticks_per_second <= cfg_data[mvc_pkg::TPS_W-1:0];
        end
        mvc_pkg::CFG_PULSE_SECONDS: begin
          cfg.pulse_seconds <= cfg_data[mvc_pkg::PULSE_W-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

endmodule

// ===== sv/mvc_step.sv =====
// Per-tick control logic: next state and result for one item.
module mvc_step (
  input  mvc_pkg::cfg_t    cfg,
  input  mvc_pkg::state_t  cur,
  input  mvc_pkg::item_t   item,
  output mvc_pkg::state_t  nxt,
  output mvc_pkg::result_t result
);

  logic [mvc_pkg::TPS_W-1:0]    div_inc;
  logic                         sec;
  logic [mvc_pkg::STATUS_W-1:0] st;
  logic [mvc_pkg::DRIVE_W-1:0]  drv;
  logic [mvc_pkg::PULSE_W-1:0]  hold;
  logic [mvc_pkg::TRAVEL_W-1:0] trav;

  always_comb begin
    div_inc = cur.second_divider + mvc_pkg::TPS_W'(1);
    sec     = (div_inc == cfg.ticks_per_second);
    st      = cur.status_flags;
    drv     = cur.drive_bits;
    hold    = cur.pulse_hold;
    trav    = cur.travel_counter;
    nxt.second_divider = sec ? '0 : div_inc;

    if (item.first_run) begin
      nxt.second_divider = '0;
      st   = '0;
      drv  = '0;
      hold = '0;
      trav = '0;
    end else if (!item.remote_mode) begin
      st   = '0;
      drv  = '0;
      hold = '0;
      trav = cfg.travel_time;
    end else begin
      st[mvc_pkg::ST_REMOTE] = 1'b1;
      if (item.cmd_stop || item.clutch_alarm) begin
        trav = cfg.travel_time;
        drv  = '0;
        drv[mvc_pkg::DRV_STOP] = 1'b1;
        hold = cfg.pulse_seconds;
        st[mvc_pkg::ST_OPENING] = 1'b0;
        st[mvc_pkg::ST_CLOSING] = 1'b0;
      end else begin
        if (item.cmd_open && !st[mvc_pkg::ST_CLOSING] && !item.limit_open &&
            !cur.drive_bits[mvc_pkg::DRV_STOP]) begin
          trav = cfg.travel_time;
          hold = cfg.pulse_seconds;
          drv[mvc_pkg::DRV_OPEN]     = 1'b1;
          st[mvc_pkg::ST_OPENING]  = 1'b1;
          st[mvc_pkg::ST_CLOSING]  = 1'b0;
          st[mvc_pkg::ST_CLUTCH]   = 1'b0;
          st[mvc_pkg::ST_TO_OPEN]  = 1'b0;
          st[mvc_pkg::ST_TO_CLOSE] = 1'b0;
        end
        if (item.cmd_close && !st[mvc_pkg::ST_OPENING] && !item.limit_closed &&
            !cur.drive_bits[mvc_pkg::DRV_STOP]) begin
          trav = cfg.travel_time;
          hold = cfg.pulse_seconds;
          drv[mvc_pkg::DRV_CLOSE]    = 1'b1;
          st[mvc_pkg::ST_CLOSING]  = 1'b1;
          st[mvc_pkg::ST_OPENING]  = 1'b0;
          st[mvc_pkg::ST_CLUTCH]   = 1'b0;
          st[mvc_pkg::ST_TO_OPEN]  = 1'b0;
          st[mvc_pkg::ST_TO_CLOSE] = 1'b0;
        end
      end

      if (hold == '0) begin
        drv = '0;
      end else if (sec) begin
        hold = hold - mvc_pkg::PULSE_W'(1);
      end

      if (st[mvc_pkg::ST_OPENING]) begin
        if (trav == '0) begin
          st[mvc_pkg::ST_OPENING] = 1'b0;
          st[mvc_pkg::ST_TO_OPEN] = 1'b1;
          drv[mvc_pkg::DRV_STOP]  = 1'b1;
          hold = cfg.pulse_seconds;
        end else if (item.limit_open) begin
          st[mvc_pkg::ST_OPENING] = 1'b0;
          st[mvc_pkg::ST_TO_OPEN] = 1'b0;
        end else if (sec) begin
          trav = trav - mvc_pkg::TRAVEL_W'(1);
        end
      end
      if (st[mvc_pkg::ST_CLOSING]) begin
        if (trav == '0) begin
          st[mvc_pkg::ST_CLOSING]  = 1'b0;
          st[mvc_pkg::ST_TO_CLOSE] = 1'b1;
          drv[mvc_pkg::DRV_STOP]   = 1'b1;
          hold = cfg.pulse_seconds;
        end else if (item.limit_closed) begin
          st[mvc_pkg::ST_CLOSING]  = 1'b0;
          st[mvc_pkg::ST_TO_CLOSE] = 1'b0;
        end else if (sec) begin
          trav = trav - mvc_pkg::TRAVEL_W'(1);
        end
      end
    end

    st[mvc_pkg::ST_CLUTCH] = item.clutch_alarm;
    st[mvc_pkg::ST_OPENED] = item.limit_open;
    st[mvc_pkg::ST_CLOSED] = item.limit_closed;
    st[mvc_pkg::ST_POWER]  = item.power_present;

    nxt.pulse_hold     = hold;
    nxt.travel_counter = trav;
    nxt.status_flags   = st;
    nxt.drive_bits     = drv;

    result.drive_open  = drv[mvc_pkg::DRV_OPEN];
    result.drive_close = drv[mvc_pkg::DRV_CLOSE];
    result.drive_stop  = drv[mvc_pkg::DRV_STOP];
    result.travel_left = trav;
    result.status_word = st;
  end

endmodule

// ===== dv/motor_valve_controller_test.sv =====
// Self-checking testbench for motor_valve_controller: random valve ticks against an inline predictor.
module motor_valve_controller_test;
  import mvc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic tick_valid = 1'b0;
  logic tick_ready;
  item_t tick_item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  result_t res_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TRAVEL_W-1:0] cfg_data = '0;

  motor_valve_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (tick_valid),
    .item_ready   (tick_ready),
    .item         (tick_item),
    .result_valid (res_valid),
    .result_ready (res_ready),
    .result       (res_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Controller copy used for prediction
  logic [TRAVEL_W-1:0] cur_travel_time = TRAVEL_TIME_RST;
  logic [TPS_W-1:0] cur_ticks_per_sec = TICKS_PER_SECOND_RST;
  logic [PULSE_W-1:0] cur_pulse_sec = PULSE_SECONDS_RST;
  logic [TPS_W-1:0] vt_divider = '0;
  logic [PULSE_W-1:0] vt_hold = '0;
  logic [TRAVEL_W-1:0] vt_travel = '0;
  logic [STATUS_W-1:0] vt_status = '0;
  logic [DRIVE_W-1:0] vt_drive = '0;

  item_t pending_ticks[$];
  result_t predicted_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int gap_left = 0;
  int hold_left = 0;
  int cycle_count = 0;
  logic fast_send = 1'b0;
  logic fast_take = 1'b0;

  function automatic result_t valve_tick(input item_t t);
    logic [STATUS_W-1:0] st;
    logic sec_tick;
    result_t r;
    sec_tick = 1'b0;
    if (t.first_run) begin
      vt_drive = '0;
      vt_travel = '0;
      vt_divider = '0;
      vt_hold = '0;
      st = '0;
    end else begin
      vt_divider = vt_divider + 8'd1;
      sec_tick = (vt_divider == cur_ticks_per_sec);
      st = vt_status;
      if (!t.remote_mode) begin
        st = '0;
        vt_travel = cur_travel_time;
        vt_drive = '0;
        vt_hold = '0;
      end else begin
        st[ST_REMOTE] = 1'b1;
        if (t.cmd_stop || t.clutch_alarm) begin
          vt_travel = cur_travel_time;
          vt_drive = '0;
          vt_drive[DRV_STOP] = 1'b1;
          vt_hold = cur_pulse_sec;
          st[ST_OPENING] = 1'b0;
          st[ST_CLOSING] = 1'b0;
        end else begin
          if (t.cmd_open && !st[ST_CLOSING] && !t.limit_open && !vt_drive[DRV_STOP]) begin
            vt_travel = cur_travel_time;
            vt_hold = cur_pulse_sec;
            vt_drive[DRV_OPEN] = 1'b1;
            st[ST_OPENING] = 1'b1;
            st[ST_CLOSING] = 1'b0;
            st[ST_CLUTCH] = 1'b0;
            st[ST_TO_OPEN] = 1'b0;
            st[ST_TO_CLOSE] = 1'b0;
          end
          if (t.cmd_close && !st[ST_OPENING] && !t.limit_closed && !vt_drive[DRV_STOP]) begin
            vt_travel = cur_travel_time;
            vt_hold = cur_pulse_sec;
            vt_drive[DRV_CLOSE] = 1'b1;
            st[ST_CLOSING] = 1'b1;
            st[ST_OPENING] = 1'b0;
            st[ST_CLUTCH] = 1'b0;
            st[ST_TO_OPEN] = 1'b0;
            st[ST_TO_CLOSE] = 1'b0;
          end
        end
        if (vt_hold == '0) vt_drive = '0;
        else if (sec_tick) vt_hold = vt_hold - 8'd1;
        if (st[ST_OPENING]) begin
          if (vt_travel == '0) begin
            st[ST_OPENING] = 1'b0;
            st[ST_TO_OPEN] = 1'b1;
            vt_drive[DRV_STOP] = 1'b1;
            vt_hold = cur_pulse_sec;
          end else if (t.limit_open) begin
            st[ST_OPENING] = 1'b0;
            st[ST_TO_OPEN] = 1'b0;
          end else if (sec_tick) begin
            vt_travel = vt_travel - 16'd1;
          end
        end
        if (st[ST_CLOSING]) begin
          if (vt_travel == '0) begin
            st[ST_CLOSING] = 1'b0;
            st[ST_TO_CLOSE] = 1'b1;
            vt_drive[DRV_STOP] = 1'b1;
            vt_hold = cur_pulse_sec;
          end else if (t.limit_closed) begin
            st[ST_CLOSING] = 1'b0;
            st[ST_TO_CLOSE] = 1'b0;
          end else if (sec_tick) begin
            vt_travel = vt_travel - 16'd1;
          end
        end
      end
    end
    st[ST_CLUTCH] = t.clutch_alarm;
    st[ST_OPENED] = t.limit_open;
    st[ST_CLOSED] = t.limit_closed;
    st[ST_POWER] = t.power_present;
    vt_status = st;
    if (vt_divider == cur_ticks_per_sec) vt_divider = '0;
    r.drive_open = vt_drive[DRV_OPEN];
    r.drive_close = vt_drive[DRV_CLOSE];
    r.drive_stop = vt_drive[DRV_STOP];
    r.travel_left = vt_travel;
    r.status_word = vt_status;
    return r;
  endfunction

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (tick_valid && tick_ready) predicted_results.push_back(valve_tick(tick_item));
      if ($urandom_range(0, 63) == 0) fast_send <= !fast_send;
      if (!tick_valid || tick_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          tick_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_item <= pending_ticks.pop_front();
          tick_valid <= 1'b1;
          gap_left <= fast_send ? 0 : $urandom_range(0, 10);
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin : receiver
    result_t want;
    int stall;
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      stall = hold_left;
      if (res_valid && res_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (res_item.drive_open !== want.drive_open) begin
            $error("drive_open: expected %0d, got %0d", want.drive_open, res_item.drive_open);
            mismatches++;
          end
          if (res_item.drive_close !== want.drive_close) begin
            $error("drive_close: expected %0d, got %0d", want.drive_close, res_item.drive_close);
            mismatches++;
          end
          if (res_item.drive_stop !== want.drive_stop) begin
            $error("drive_stop: expected %0d, got %0d", want.drive_stop, res_item.drive_stop);
            mismatches++;
          end
          if (res_item.travel_left !== want.travel_left) begin
            $error("travel_left: expected %0d, got %0d", want.travel_left, res_item.travel_left);
            mismatches++;
          end
          if (res_item.status_word !== want.status_word) begin
            $error("status_word: expected 0x%03h, got 0x%03h",
                   want.status_word, res_item.status_word);
            mismatches++;
          end
        end
        // hold off long enough to back up the pipeline
        if (results_seen == 100 || results_seen == 500) stall = 200;
        else stall = fast_take ? 0 : $urandom_range(0, 10);
      end
      if ($urandom_range(0, 63) == 0) fast_take <= !fast_take;
      if (stall > 0) begin
        res_ready <= 1'b0;
        hold_left <= stall - 1;
      end else begin
        res_ready <= 1'b1;
        hold_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_raw(input logic [8:0] bits);
    pending_ticks.push_back(item_t'(bits));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [TRAVEL_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TRAVEL_TIME: cur_travel_time = val;
      CFG_TICKS_PER_SECOND: cur_ticks_per_sec = val[TPS_W-1:0];
      CFG_PULSE_SECONDS: cur_pulse_sec = val[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int travel, input int tps, input int pulse);
    write_reg(CFG_TRAVEL_TIME, travel[TRAVEL_W-1:0]);
    write_reg(CFG_TICKS_PER_SECOND, tps[TRAVEL_W-1:0]);
    write_reg(CFG_PULSE_SECONDS, pulse[TRAVEL_W-1:0]);
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || tick_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One open or close move: command, travel ticks, then usually the limit switch.
  task automatic push_move(output int added);
    item_t t;
    int n;
    logic to_open;
    to_open = 1'($urandom_range(0, 1));
    t = '0;
    t.remote_mode = 1'b1;
    t.power_present = ($urandom_range(0, 7) != 0);
    t.cmd_open = to_open;
    t.cmd_close = !to_open;
    if ($urandom_range(0, 9) == 0) begin
      t.cmd_open = 1'b1;
      t.cmd_close = 1'b1;
    end
    if ($urandom_range(0, 9) == 0) t.limit_open = 1'b1;
    if ($urandom_range(0, 9) == 0) t.limit_closed = 1'b1;
    pending_ticks.push_back(t);
    added = 1;
    n = $urandom_range(0, 15);
    repeat (n) begin
      t.cmd_open = ($urandom_range(0, 14) == 0);
      t.cmd_close = ($urandom_range(0, 14) == 0);
      t.cmd_stop = ($urandom_range(0, 24) == 0);
      t.clutch_alarm = ($urandom_range(0, 39) == 0);
      t.limit_open = 1'b0;
      t.limit_closed = 1'b0;
      pending_ticks.push_back(t);
      added++;
    end
    if ($urandom_range(0, 3) != 0) begin
      t.cmd_open = 1'b0;
      t.cmd_close = 1'b0;
      t.cmd_stop = 1'b0;
      t.clutch_alarm = 1'b0;
      t.limit_open = to_open;
      t.limit_closed = !to_open;
      repeat ($urandom_range(1, 3)) begin
        pending_ticks.push_back(t);
        added++;
      end
    end
    if ($urandom_range(0, 19) == 0) begin
      t.remote_mode = 1'b0;
      pending_ticks.push_back(t);
      added++;
    end
  endtask

  task automatic fill_ticks(input int n);
    int added;
    int k;
    logic [8:0] raw;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 3) begin
        raw = 9'($urandom);
        push_raw(raw);
        added++;
      end else begin
        push_move(k);
        added += k;
      end
    end
  endtask

  initial begin : stim
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // field order: first, remote, open, close, stop, alarm, limit open, limit closed, power
    push_raw(9'b0_0_0_0_0_0_0_0_0);
    push_raw(9'b1_1_1_1_1_1_1_1_1);
    push_raw(9'b1_0_0_0_0_0_0_0_0);
    push_raw(9'b0_1_0_0_0_0_0_0_1);
    push_raw(9'b0_1_1_1_0_0_0_0_1);
    push_raw(9'b0_1_0_1_0_0_0_0_1);
    push_raw(9'b0_1_0_0_0_0_1_0_1);
    push_raw(9'b0_1_1_0_0_0_1_0_1);
    push_raw(9'b0_1_0_1_0_0_1_0_1);
    push_raw(9'b0_1_0_0_1_0_0_0_1);
    push_raw(9'b0_1_1_0_0_0_0_0_1);
    push_raw(9'b0_1_0_0_0_1_0_0_0);
    push_raw(9'b0_1_0_1_0_0_0_1_0);
    push_raw(9'b0_0_1_1_1_1_1_1_1);
    push_raw(9'b0_1_1_0_0_0_0_0_1);
    push_raw(9'b0_1_0_0_0_0_0_0_1);
    push_raw(9'b0_1_1_1_1_1_0_0_1);
    push_raw(9'b1_1_1_0_0_0_0_0_1);
    push_raw(9'b0_1_0_1_0_0_0_0_1);
    push_raw(9'b0_1_0_0_0_0_0_1_1);
    push_raw(9'b0_0_0_0_0_0_0_0_0);
    wait_drained();

    set_regs(3, 1, 1);
    fill_ticks(122);
    wait_drained();

    set_regs(0, 1, 255);
    fill_ticks(122);
    wait_drained();

    set_regs(65535, 255, 1);
    fill_ticks(122);
    wait_drained();

    set_regs(5, 2, 3);
    fill_ticks(122);
    wait_drained();

    repeat (2) begin
      set_regs($urandom_range(0, 30), $urandom_range(1, 3), $urandom_range(1, 4));
      fill_ticks(122);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mvc_pkg.sv
sv/mvc_cfg_regs.sv
sv/mvc_step.sv
sv/motor_valve_controller.sv
dv/motor_valve_controller_test.sv
